/* src/rscm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscm_pkg
// Shared widths, defaults, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package rscm_pkg;

  localparam int VALUE_W          = 16;
  localparam int CFG_W            = 5;
  localparam int MAX_VALUES_DEF   = 64;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam logic [CFG_W-1:0] CLUSTERS_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_EVAL,
    ST_NEXT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store;
    logic scan_init;
    logic scan_run;
    logic take_first;
    logic accum;
    logic restart;
    logic div_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic has_cur;
    logic split;
    logic more;
    logic limit_hit;
    logic div_done;
  } sts_t;

endpackage

/* src/rscm_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscm_divider
// Restoring divider, one quotient bit per cycle, for the cluster mean.
// ----------------------------------------------------------------------------
module rscm_divider #(
  parameter int SUM_W = 22,
  parameter int CNT_W = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [SUM_W-1:0]            dividend,
  input  logic [CNT_W-1:0]            divisor,
  output logic                        done,
  output logic [rscm_pkg::VALUE_W-1:0] quotient
);

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic [ITER_W-1:0] iter;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial    = {rem, quo[SUM_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo[rscm_pkg::VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        iter <= ITER_W'(SUM_W);
      end else if (iter != '0) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (iter != '0) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
    end
  end

endmodule

/* src/rscm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscm_datapath
// Value store, ordered scan for the next key, cluster sums and mean divider.
// ----------------------------------------------------------------------------
module rscm_datapath #(
  parameter int MAX_VALUES   = rscm_pkg::MAX_VALUES_DEF,
  parameter int MAX_CLUSTERS = rscm_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rscm_pkg::cmd_t                cmd,
  output rscm_pkg::sts_t                sts,
  input  logic [rscm_pkg::VALUE_W-1:0]  sample_value,
  input  logic                          cfg_valid,
  input  logic [rscm_pkg::CFG_W-1:0]    cfg_data,
  output logic [rscm_pkg::VALUE_W-1:0]  cluster_mean
);

  localparam int VW     = rscm_pkg::VALUE_W;
  localparam int CNT_W  = $clog2(MAX_VALUES + 1);
  localparam int IDX_W  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int SUM_W  = $clog2(MAX_VALUES * (2 ** VW - 1) + 1);
  localparam int KEY_W  = VW + IDX_W;
  localparam int EMIT_W = $clog2(MAX_CLUSTERS + 1);

  logic [VW-1:0]     mem [MAX_VALUES];
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  scan_idx;
  logic [VW-1:0]     rd_data;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_vld;
  logic [KEY_W-1:0]  best_key;
  logic              found;
  logic [KEY_W-1:0]  cur_key;
  logic              has_cur;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  members;
  logic [CNT_W-1:0]  step;
  logic [EMIT_W-1:0] emitted;
  logic [rscm_pkg::CFG_W-1:0] max_clusters;

  logic [KEY_W-1:0]  cand;
  logic              eligible;
  logic [VW-1:0]     best_val;
  logic [VW-1:0]     cur_val;
  logic [VW:0]       bound;
  logic [EMIT_W-1:0] limit;
  logic              full;

  assign cand     = {rd_data, rd_idx};
  assign eligible = !has_cur || (cand > cur_key);
  assign best_val = best_key[KEY_W-1:IDX_W];
  assign cur_val  = cur_key[KEY_W-1:IDX_W];
  assign bound    = {1'b0, cur_val} + {2'b00, cur_val[VW-1:1]};
  assign full     = count >= CNT_W'(MAX_VALUES);

  always_comb begin
    if (max_clusters == '0 || 32'(max_clusters) > 32'(MAX_CLUSTERS)) begin
      limit = EMIT_W'(MAX_CLUSTERS);
    end else begin
      limit = EMIT_W'(max_clusters);
    end
  end

  assign sts.scan_last = CNT_W'(scan_idx) == (count - 1'b1);
  assign sts.has_cur   = has_cur;
  assign sts.split     = {1'b0, best_val} > bound;
  assign sts.more      = step < count;
  assign sts.limit_hit = ((EMIT_W + 1)'(emitted) + 1'b1) >= (EMIT_W + 1)'(limit);

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem[count[IDX_W-1:0]] <= sample_value;
    end
    rd_data <= mem[scan_idx];
    rd_idx  <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_clusters <= rscm_pkg::CLUSTERS_RESET;
    end else if (cfg_valid) begin
      max_clusters <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
      has_cur  <= 1'b0;
      step     <= '0;
      members  <= '0;
      emitted  <= '0;
      sum      <= '0;
    end else begin
      rd_vld <= cmd.scan_run;
      if (cmd.store && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.scan_init) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (cmd.scan_run) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rd_vld && eligible && (!found || cand < best_key)) begin
        best_key <= cand;
        found    <= 1'b1;
      end
      if (cmd.take_first) begin
        cur_key <= best_key;
        has_cur <= 1'b1;
        sum     <= SUM_W'(best_val);
        members <= CNT_W'(1);
        step    <= CNT_W'(1);
      end
      if (cmd.accum) begin
        cur_key <= best_key;
        sum     <= sum + SUM_W'(best_val);
        members <= members + 1'b1;
        step    <= step + 1'b1;
      end
      if (cmd.restart) begin
        cur_key <= best_key;
        sum     <= SUM_W'(best_val);
        members <= CNT_W'(1);
        step    <= step + 1'b1;
        emitted <= emitted + 1'b1;
      end
      if (cmd.finish) begin
        count   <= '0;
        has_cur <= 1'b0;
        step    <= '0;
        members <= '0;
        emitted <= '0;
        sum     <= '0;
      end
    end
  end

  rscm_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (members),
    .done     (sts.div_done),
    .quotient (cluster_mean)
  );

endmodule

/* src/rscm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscm_ctrl
// Sequencer for load, ordered walk, cluster split and mean output.
// ----------------------------------------------------------------------------
module rscm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last_value,
  input  rscm_pkg::sts_t sts,
  output rscm_pkg::cmd_t cmd,
  output logic           busy,
  output logic           result_valid,
  output logic           last_cluster
);

  rscm_pkg::state_t state, state_next;
  logic             final_mean, final_mean_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rscm_pkg::ST_IDLE;
      final_mean <= 1'b0;
    end else begin
      state      <= state_next;
      final_mean <= final_mean_next;
    end
  end

  always_comb begin
    state_next      = state;
    final_mean_next = final_mean;
    cmd             = '0;
    busy            = 1'b1;
    result_valid    = 1'b0;
    last_cluster    = 1'b0;
    case (state)
      rscm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.store = 1'b1;
          if (last_value) begin
            cmd.scan_init = 1'b1;
            state_next    = rscm_pkg::ST_SCAN;
          end
        end
      end
      rscm_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_last) begin
          state_next = rscm_pkg::ST_TAIL;
        end
      end
      rscm_pkg::ST_TAIL: begin
        state_next = rscm_pkg::ST_EVAL;
      end
      rscm_pkg::ST_EVAL: begin
        if (!sts.has_cur) begin
          cmd.take_first = 1'b1;
          state_next     = rscm_pkg::ST_NEXT;
        end else if (sts.split) begin
          cmd.div_start   = 1'b1;
          final_mean_next = 1'b0;
          state_next      = rscm_pkg::ST_DIV;
        end else begin
          cmd.accum  = 1'b1;
          state_next = rscm_pkg::ST_NEXT;
        end
      end
      rscm_pkg::ST_NEXT: begin
        if (sts.more) begin
          cmd.scan_init = 1'b1;
          state_next    = rscm_pkg::ST_SCAN;
        end else begin
          cmd.div_start   = 1'b1;
          final_mean_next = 1'b1;
          state_next      = rscm_pkg::ST_DIV;
        end
      end
      rscm_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_next = rscm_pkg::ST_EMIT;
        end
      end
      rscm_pkg::ST_EMIT: begin
        result_valid = 1'b1;
        if (final_mean || sts.limit_hit) begin
          last_cluster = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = rscm_pkg::ST_IDLE;
        end else begin
          cmd.restart = 1'b1;
          state_next  = rscm_pkg::ST_NEXT;
        end
      end
      default: begin
        state_next = rscm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/ratio_step_cluster_means.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratio_step_cluster_means
// Loads pulse lengths, walks them in ascending order and emits cluster means.
// ----------------------------------------------------------------------------
// Load: one item per cycle while busy is low; an item without last_value
//   leaves busy low.
// After the last item: each walk step scans all N stored values through the
//   store's read port; each mean is worked out in the bit-serial divider.
// Each mean is shown for one cycle on result_valid; the receiver cannot stall.
// Reset: max_clusters returns to 16, counters clear; store contents undefined.
// ----------------------------------------------------------------------------
module ratio_step_cluster_means #(
  parameter int MAX_VALUES   = rscm_pkg::MAX_VALUES_DEF,
  parameter int MAX_CLUSTERS = rscm_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rscm_pkg::VALUE_W-1:0]  sample_value,
  input  logic                          last_value,
  output logic                          result_valid,
  output logic [rscm_pkg::VALUE_W-1:0]  cluster_mean,
  output logic                          last_cluster,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rscm_pkg::CFG_W-1:0]    cfg_data
);

  rscm_pkg::cmd_t cmd;
  rscm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rscm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_value   (last_value),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .last_cluster (last_cluster)
  );

  rscm_datapath #(
    .MAX_VALUES   (MAX_VALUES),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .sample_value (sample_value),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cluster_mean (cluster_mean)
  );

endmodule

/* src/rscm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscm_checker
// Port-level checks of the load/walk/emit sequence.
// ----------------------------------------------------------------------------
module rscm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_value,
  input logic result_valid,
  input logic last_cluster
);

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result outside a walk");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_value) |=> !busy)
    else $error("busy after a non-last item");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_value) |=> busy)
    else $error("walk did not start after last item");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_cluster) |=> !busy)
    else $error("busy after final mean");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_cluster) |=> busy)
    else $error("walk ended without final mean");

endmodule

bind ratio_step_cluster_means rscm_checker u_rscm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .last_value   (last_value),
  .result_valid (result_valid),
  .last_cluster (last_cluster)
);

/* tb/cluster_mean_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_mean_checker
// Watches the item, result and limit channels of ratio_step_cluster_means,
// keeps its own copy of the loaded values and the cluster limit, predicts the
// cluster means of every closed set and compares them in order.
// ----------------------------------------------------------------------------
module cluster_mean_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [rscm_pkg::VALUE_W-1:0]  sample_value,
  input  logic                          last_value,
  input  logic                          result_valid,
  input  logic [rscm_pkg::VALUE_W-1:0]  cluster_mean,
  input  logic                          last_cluster,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rscm_pkg::CFG_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            means_checked
);
  import rscm_pkg::*;

  localparam int STORE_DEPTH = MAX_VALUES_DEF;
  localparam int LIMIT_CAP   = MAX_CLUSTERS_DEF;

  typedef struct packed {
    logic [VALUE_W-1:0] mean;
    logic               last;
  } mean_t;

  mean_t              expected_means[$];
  logic [VALUE_W-1:0] held_values[STORE_DEPTH];
  int unsigned        held_count;
  logic [CFG_W-1:0]   cluster_limit;

  function automatic void predict_cluster_means();
    logic [VALUE_W-1:0] sorted_values[STORE_DEPTH];
    logic [VALUE_W-1:0] pick;
    logic [VALUE_W:0]   reach;
    logic [21:0]        sum;
    logic [6:0]         members;
    logic [CFG_W-1:0]   cap;
    logic [CFG_W-1:0]   emitted;
    mean_t              m;
    int                 j;
    for (int i = 0; i < held_count; i++) sorted_values[i] = held_values[i];
    for (int i = 1; i < held_count; i++) begin
      pick = sorted_values[i];
      j = i;
      while (j > 0 && sorted_values[j-1] > pick) begin
        sorted_values[j] = sorted_values[j-1];
        j--;
      end
      sorted_values[j] = pick;
    end
    cap = (cluster_limit == 0 || cluster_limit > LIMIT_CAP) ? CFG_W'(LIMIT_CAP) : cluster_limit;
    sum = 22'(sorted_values[0]);
    members = 7'd1;
    emitted = '0;
    for (int i = 1; i < held_count; i++) begin
      reach = {1'b0, sorted_values[i-1]} + (sorted_values[i-1] >> 1);
      if ({1'b0, sorted_values[i]} > reach) begin
        m.mean = VALUE_W'(sum / members);
        emitted++;
        if (emitted >= cap) begin
          m.last = 1'b1;
          expected_means.push_back(m);
          held_count = 0;
          return;
        end
        m.last = 1'b0;
        expected_means.push_back(m);
        sum = '0;
        members = '0;
      end
      sum += 22'(sorted_values[i]);
      members++;
    end
    m.mean = VALUE_W'(sum / members);
    m.last = 1'b1;
    expected_means.push_back(m);
    held_count = 0;
  endfunction

  always @(posedge clk) begin
    mean_t want;
    if (rst) begin
      expected_means.delete();
      held_count = 0;
      cluster_limit = CLUSTERS_RESET;
      fail_count = 0;
      means_checked = 0;
    end else begin
      if (result_valid) begin
        if (expected_means.size() == 0) begin
          $error("unexpected cluster_mean %0d last_cluster %0b", cluster_mean, last_cluster);
          fail_count++;
        end else begin
          want = expected_means.pop_front();
          means_checked++;
          if (cluster_mean !== want.mean) begin
            $error("cluster_mean: expected %0d, got %0d", want.mean, cluster_mean);
            fail_count++;
          end
          if (last_cluster !== want.last) begin
            $error("last_cluster: expected %0b, got %0b", want.last, last_cluster);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) cluster_limit = cfg_data;
      if (start && !busy) begin
        if (held_count < STORE_DEPTH) begin
          held_values[held_count] = sample_value;
          held_count++;
        end
        if (last_value) predict_cluster_means();
      end
    end
    pending = expected_means.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives ratio_step_cluster_means with directed and random sets of pulse
// lengths under a range of cluster limits, with random gaps between items;
// the checker beside the block predicts and compares every cluster mean.
// ----------------------------------------------------------------------------
module tb;
  import rscm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 380;
  localparam int SETTLE       = 100;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] sample_value;
  logic               last_value;
  logic               result_valid;
  logic [VALUE_W-1:0] cluster_mean;
  logic               last_cluster;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int means_checked;
  int cycles;
  int items_sent;
  int sets_sent;
  int limits_used;
  logic quiet;

  logic [VALUE_W-1:0] centers[5];
  logic [CFG_W-1:0]   limit_plan[5] = '{5'd0, 5'd31, 5'd2, 5'd17, 5'd1};

  ratio_step_cluster_means DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_value (sample_value),
    .last_value   (last_value),
    .result_valid (result_valid),
    .cluster_mean (cluster_mean),
    .last_cluster (last_cluster),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  cluster_mean_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sample_value  (sample_value),
    .last_value    (last_value),
    .result_valid  (result_valid),
    .cluster_mean  (cluster_mean),
    .last_cluster  (last_cluster),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .means_checked (means_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ratio_step_cluster_means: mismatch");
      $finish;
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v, input logic fin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    sample_value <= v;
    last_value <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (fin) sets_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limits_used++;
  endtask

  function automatic logic [VALUE_W-1:0] draw_value(int mode, int ncent);
    logic [VALUE_W-1:0] c;
    case (mode)
      0: begin
        return VALUE_W'($urandom_range(0, 65535));
      end
      1: begin
        c = centers[$urandom_range(0, ncent - 1)];
        return c + VALUE_W'($urandom_range(0, c / 4));
      end
      default: begin
        return VALUE_W'($urandom_range(0, 63));
      end
    endcase
  endfunction

  initial begin
    int random_sent;
    int set_size;
    int mode;
    int ncent;
    int phase;
    int sets_in_phase;
    rst = 1'b1;
    start = 1'b0;
    sample_value = '0;
    last_value = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    items_sent = 0;
    sets_sent = 0;
    limits_used = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_value(16'd0, 1'b1);
    send_value(16'd65535, 1'b1);
    send_value(16'd43690, 1'b0);
    send_value(16'd65535, 1'b1);
    send_value(16'd65535, 1'b0);
    send_value(16'd43690, 1'b0);
    send_value(16'd65535, 1'b0);
    send_value(16'd43691, 1'b1);
    send_value(16'd7, 1'b0);
    send_value(16'd7, 1'b0);
    send_value(16'd7, 1'b1);
    send_value(16'd3, 1'b0);
    send_value(16'd1, 1'b0);
    send_value(16'd2, 1'b1);
    send_value(16'd200, 1'b0);
    send_value(16'd1, 1'b0);
    send_value(16'd100, 1'b0);
    send_value(16'd20, 1'b0);
    send_value(16'd0, 1'b0);
    send_value(16'd65535, 1'b1);
    drain();
    write_limit(5'd1);
    send_value(16'd5, 1'b0);
    send_value(16'd50, 1'b0);
    send_value(16'd500, 1'b1);
    drain();

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      write_limit(phase < 5 ? limit_plan[phase] : CFG_W'($urandom_range(0, 31)));
      quiet = ($urandom_range(0, 3) == 0);
      sets_in_phase = $urandom_range(2, 6);
      for (int s = 0; s < sets_in_phase; s++) begin
        case ($urandom_range(0, 19))
          0:          set_size = $urandom_range(56, 72);
          1, 2, 3, 4: set_size = $urandom_range(9, 24);
          default:    set_size = $urandom_range(1, 8);
        endcase
        if (phase == 0 && s == 0) set_size = 70;
        mode = $urandom_range(0, 2);
        ncent = $urandom_range(1, 5);
        for (int k = 0; k < 5; k++) centers[k] = VALUE_W'($urandom_range(0, 52000));
        for (int n = 0; n < set_size; n++) begin
          send_value(draw_value(mode, ncent), n == set_size - 1);
          random_sent++;
        end
      end
      drain();
      phase++;
    end

    $display("Sent %0d values in %0d sets under %0d cluster limit settings.",
             items_sent, sets_sent, limits_used);
    $display("Checked %0d cluster means, with store overflow and limit saturation included.",
             means_checked);
    if (fail_count == 0) begin
      $display("ratio_step_cluster_means: match");
    end else begin
      $display("ratio_step_cluster_means: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rscm_pkg.sv
src/rscm_divider.sv
src/rscm_datapath.sv
src/rscm_ctrl.sv
src/ratio_step_cluster_means.sv
src/rscm_checker.sv
tb/cluster_mean_checker.sv
tb/tb.sv
